FILE: rtl/core/pupt_pkg.sv
// Shared types, constants and microcode program of the pose update and point transform block.
`default_nettype none

package pupt_pkg;

  localparam int QUAT_FRAC_BITS_DEF = 14;
  localparam int ATT_SHIFT = 30;
  localparam int PC_W = 4;

  localparam logic signed [31:0] HALF_SQRT2_Q30 = 32'sd759250125;
  localparam logic [15:0] Q16_MAX = 16'h7fff;
  localparam logic [15:0] Q16_MIN = 16'h8000;
  localparam logic [31:0] C32_MAX = 32'h7fffffff;
  localparam logic [31:0] C32_MIN = 32'h80000000;

  localparam logic ACT_ODOM = 1'b0;
  localparam logic ACT_POINT = 1'b1;

  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_ATT_A = 3'd1;
  localparam logic [2:0] MUL_ATT_B = 3'd2;
  localparam logic [2:0] MUL_SQ_A = 3'd3;
  localparam logic [2:0] MUL_SQ_B = 3'd4;
  localparam logic [2:0] MUL_SQ_C = 3'd5;
  localparam logic [2:0] MUL_SQ_D = 3'd6;
  localparam logic [2:0] MUL_ROW = 3'd7;

  localparam logic [3:0] WB_NONE = 4'd0;
  localparam logic [3:0] WB_ATT_WXY = 4'd1;
  localparam logic [3:0] WB_ATT_Z = 4'd2;
  localparam logic [3:0] WB_PROD_A = 4'd3;
  localparam logic [3:0] WB_PROD_B = 4'd4;
  localparam logic [3:0] WB_PROD_C = 4'd5;
  localparam logic [3:0] WB_PROD_D = 4'd6;
  localparam logic [3:0] WB_MAT = 4'd7;
  localparam logic [3:0] WB_RES = 4'd8;

  localparam logic [1:0] ROW_X = 2'd0;
  localparam logic [1:0] ROW_Y = 2'd1;
  localparam logic [1:0] ROW_Z = 2'd2;

  localparam logic [1:0] SEQ_NEXT = 2'd0;
  localparam logic [1:0] SEQ_WAIT = 2'd1;
  localparam logic [1:0] SEQ_SKIP = 2'd2;
  localparam logic [1:0] SEQ_EMIT = 2'd3;

  localparam logic [PC_W-1:0] ADDR_IDLE = 4'd0;
  localparam logic [PC_W-1:0] ADDR_ODOM = 4'd1;
  localparam logic [PC_W-1:0] ADDR_POINT = 4'd12;

  typedef struct packed {
    logic [2:0] mul;
    logic [3:0] wb;
    logic [1:0] mrow;
    logic [1:0] wrow;
    logic [1:0] seq;
    logic [PC_W-1:0] target;
  } cw_t;

  typedef struct packed {
    logic in_valid;
    logic action;
    logic slot_free;
    logic pose_valid;
  } seq_stat_t;

  typedef struct packed {
    logic ready;
    logic accept;
    logic emit;
  } seq_ctl_t;

  typedef struct packed {
    logic kind;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [15:0] att_out_w;
    logic [15:0] att_out_x;
    logic [15:0] att_out_y;
    logic [15:0] att_out_z;
    logic [31:0] extra_a;
    logic [31:0] extra_b;
    logic [31:0] extra_c;
    logic end_of_cloud;
  } out_item_t;

  function automatic cw_t cw(input logic [2:0] mul, input logic [3:0] wb,
                             input logic [1:0] mrow, input logic [1:0] wrow,
                             input logic [1:0] seq, input logic [PC_W-1:0] target);
    cw_t w;
    w.mul = mul;
    w.wb = wb;
    w.mrow = mrow;
    w.wrow = wrow;
    w.seq = seq;
    w.target = target;
    return w;
  endfunction

  function automatic cw_t ucode(input logic [PC_W-1:0] addr);
    cw_t w;
    unique case (addr)
      4'd0: w = cw(MUL_NONE, WB_NONE, ROW_X, ROW_X, SEQ_WAIT, ADDR_IDLE);
      4'd1: w = cw(MUL_ATT_A, WB_NONE, ROW_X, ROW_X, SEQ_NEXT, ADDR_IDLE);
      4'd2: w = cw(MUL_ATT_B, WB_ATT_WXY, ROW_X, ROW_X, SEQ_NEXT, ADDR_IDLE);
      4'd3: w = cw(MUL_NONE, WB_ATT_Z, ROW_X, ROW_X, SEQ_NEXT, ADDR_IDLE);
      4'd4: w = cw(MUL_SQ_A, WB_NONE, ROW_X, ROW_X, SEQ_NEXT, ADDR_IDLE);
      4'd5: w = cw(MUL_SQ_B, WB_PROD_A, ROW_X, ROW_X, SEQ_NEXT, ADDR_IDLE);
      4'd6: w = cw(MUL_SQ_C, WB_PROD_B, ROW_X, ROW_X, SEQ_NEXT, ADDR_IDLE);
      4'd7: w = cw(MUL_SQ_D, WB_PROD_C, ROW_X, ROW_X, SEQ_NEXT, ADDR_IDLE);
      4'd8: w = cw(MUL_NONE, WB_PROD_D, ROW_X, ROW_X, SEQ_NEXT, ADDR_IDLE);
      4'd9: w = cw(MUL_NONE, WB_MAT, ROW_X, ROW_X, SEQ_NEXT, ADDR_IDLE);
      4'd10: w = cw(MUL_NONE, WB_MAT, ROW_X, ROW_Y, SEQ_NEXT, ADDR_IDLE);
      4'd11: w = cw(MUL_NONE, WB_MAT, ROW_X, ROW_Z, SEQ_EMIT, ADDR_IDLE);
      4'd12: w = cw(MUL_ROW, WB_NONE, ROW_X, ROW_X, SEQ_SKIP, ADDR_IDLE);
      4'd13: w = cw(MUL_ROW, WB_RES, ROW_Y, ROW_X, SEQ_NEXT, ADDR_IDLE);
      4'd14: w = cw(MUL_ROW, WB_RES, ROW_Z, ROW_Y, SEQ_NEXT, ADDR_IDLE);
      4'd15: w = cw(MUL_NONE, WB_RES, ROW_X, ROW_Z, SEQ_EMIT, ADDR_IDLE);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pupt_seq.sv
// Microcode sequencer: step counter, program table lookup and request handshake.
`default_nettype none

module pupt_seq (
  input  logic                clk,
  input  logic                rst,
  input  pupt_pkg::seq_stat_t stat,
  output pupt_pkg::cw_t       cw,
  output pupt_pkg::seq_ctl_t  ctl
);

  logic [pupt_pkg::PC_W-1:0] pc;
  logic [pupt_pkg::PC_W-1:0] pc_next;
  logic [pupt_pkg::PC_W-1:0] dispatch;

  always_comb begin
    cw = pupt_pkg::ucode(pc);
    ctl.ready = (cw.seq == pupt_pkg::SEQ_WAIT) ||
                (cw.seq == pupt_pkg::SEQ_EMIT && stat.slot_free);
    ctl.accept = ctl.ready && stat.in_valid;
    ctl.emit = (cw.seq == pupt_pkg::SEQ_EMIT) && stat.slot_free;
    dispatch = (stat.action == pupt_pkg::ACT_POINT) ? pupt_pkg::ADDR_POINT
                                                     : pupt_pkg::ADDR_ODOM;
    unique case (cw.seq)
      pupt_pkg::SEQ_NEXT: pc_next = pc + 4'd1;
      pupt_pkg::SEQ_WAIT: pc_next = ctl.accept ? dispatch : pc;
      pupt_pkg::SEQ_SKIP: pc_next = stat.pose_valid ? pc + 4'd1 : cw.target;
      pupt_pkg::SEQ_EMIT: begin
        if (stat.slot_free) begin
          pc_next = ctl.accept ? dispatch : pupt_pkg::ADDR_IDLE;
        end else begin
          pc_next = pc;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= pupt_pkg::ADDR_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  a_dispatch: assert property (@(posedge clk) disable iff (rst)
    ctl.accept |=> (pc == pupt_pkg::ADDR_ODOM || pc == pupt_pkg::ADDR_POINT))
    else $error("Accepted request did not start a program.");

  a_drop_point: assert property (@(posedge clk) disable iff (rst)
    (ctl.accept && stat.action == pupt_pkg::ACT_POINT && !stat.pose_valid)
      |=> ##1 (pc == pupt_pkg::ADDR_IDLE))
    else $error("Point without a pose did not return to idle.");

endmodule

`default_nettype wire

FILE: rtl/core/pupt_dp.sv
// Datapath: request latch, pose state, three shared multipliers, matrix and result logic.
`default_nettype none

module pupt_dp #(
  parameter int QUAT_FRAC_BITS = pupt_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pupt_pkg::cw_t        cw,
  input  pupt_pkg::seq_ctl_t   ctl,
  input  logic                 action,
  input  logic signed [31:0]   vec_x,
  input  logic signed [31:0]   vec_y,
  input  logic signed [31:0]   vec_z,
  input  logic signed [15:0]   quat_w,
  input  logic signed [15:0]   quat_x,
  input  logic signed [15:0]   quat_y,
  input  logic signed [15:0]   quat_z,
  input  logic signed [31:0]   aux_a,
  input  logic signed [31:0]   aux_b,
  input  logic signed [31:0]   aux_c,
  input  logic                 last_point,
  output logic                 pose_valid,
  output pupt_pkg::out_item_t  result
);

  localparam int M_W = 34 - QUAT_FRAC_BITS;
  localparam int P_W = M_W + 32;
  localparam int S_W = P_W + 2;
  localparam int E_W = 35;
  localparam logic signed [P_W-1:0] ATT_HALF = P_W'(1) << (pupt_pkg::ATT_SHIFT - 1);
  localparam logic signed [S_W-1:0] ROW_HALF = S_W'(1) << (QUAT_FRAC_BITS - 1);
  localparam logic signed [E_W-1:0] ENT_HALF = E_W'(1) << (QUAT_FRAC_BITS - 1);
  localparam logic [15:0] ATT_ONE = 16'(1 << QUAT_FRAC_BITS);

  logic               item_action;
  logic signed [31:0] item_vx;
  logic signed [31:0] item_vy;
  logic signed [31:0] item_vz;
  logic signed [15:0] item_qw;
  logic signed [15:0] item_qx;
  logic signed [15:0] item_qy;
  logic signed [15:0] item_qz;
  logic signed [31:0] item_aa;
  logic signed [31:0] item_ab;
  logic signed [31:0] item_ac;
  logic               item_last;

  logic signed [31:0] origin_east;
  logic signed [31:0] origin_north;
  logic signed [31:0] origin_up;
  logic signed [15:0] att_w;
  logic signed [15:0] att_x;
  logic signed [15:0] att_y;
  logic signed [15:0] att_z;

  logic signed [M_W-1:0] op_a [3];
  logic signed [31:0]    op_b [3];
  logic signed [P_W-1:0] mul_out [3];
  logic signed [P_W-1:0] p [3];

  logic signed [31:0] pww, pxx, pyy, pzz, pxy, pwz, pxz, pwy, pyz, pwx;
  logic signed [E_W-1:0] eww, exx, eyy, ezz, exy, ewz, exz, ewy, eyz, ewx;
  logic signed [E_W-1:0] ent [3];
  logic signed [M_W-1:0] mat [3][3];

  logic signed [M_W-1:0] iqw, iqx, iqy, iqz;
  logic signed [M_W-1:0] aw, ax, ay, az;
  logic signed [31:0]    bw, bx, by, bz;

  logic signed [31:0]  row_origin;
  logic signed [S_W-1:0] row_sum;
  logic signed [S_W-1:0] row_shift;
  logic signed [31:0]  row_out;
  logic signed [31:0]  res [3];
  logic signed [31:0]  res_next [3];

  function automatic logic [15:0] att_round(input logic signed [P_W-1:0] v);
    logic signed [P_W-1:0] t;
    t = (v + ATT_HALF) >>> pupt_pkg::ATT_SHIFT;
    if (t[P_W-1:15] == '0 || t[P_W-1:15] == '1) begin
      return t[15:0];
    end else if (t[P_W-1]) begin
      return pupt_pkg::Q16_MIN;
    end else begin
      return pupt_pkg::Q16_MAX;
    end
  endfunction

  function automatic logic [M_W-1:0] ent_round(input logic signed [E_W-1:0] v);
    logic signed [E_W-1:0] t;
    t = (v + ENT_HALF) >>> QUAT_FRAC_BITS;
    return t[M_W-1:0];
  endfunction

  function automatic logic [31:0] neg_sat(input logic [31:0] v);
    if (v == pupt_pkg::C32_MIN) begin
      return pupt_pkg::C32_MAX;
    end else begin
      return 32'(-v);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      item_action <= action;
      item_vx <= vec_x;
      item_vy <= vec_y;
      item_vz <= vec_z;
      item_qw <= quat_w;
      item_qx <= quat_x;
      item_qy <= quat_y;
      item_qz <= quat_z;
      item_aa <= aux_a;
      item_ab <= aux_b;
      item_ac <= aux_c;
      item_last <= last_point;
    end
  end

  assign iqw = {{(M_W-16){item_qw[15]}}, item_qw};
  assign iqx = {{(M_W-16){item_qx[15]}}, item_qx};
  assign iqy = {{(M_W-16){item_qy[15]}}, item_qy};
  assign iqz = {{(M_W-16){item_qz[15]}}, item_qz};
  assign aw = {{(M_W-16){att_w[15]}}, att_w};
  assign ax = {{(M_W-16){att_x[15]}}, att_x};
  assign ay = {{(M_W-16){att_y[15]}}, att_y};
  assign az = {{(M_W-16){att_z[15]}}, att_z};
  assign bw = {{16{att_w[15]}}, att_w};
  assign bx = {{16{att_x[15]}}, att_x};
  assign by = {{16{att_y[15]}}, att_y};
  assign bz = {{16{att_z[15]}}, att_z};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      op_a[k] = '0;
      op_b[k] = '0;
    end
    unique case (cw.mul)
      pupt_pkg::MUL_NONE: begin
      end
      pupt_pkg::MUL_ATT_A: begin
        op_a[0] = -(iqw + iqz);
        op_a[1] = -(iqx + iqy);
        op_a[2] = iqy - iqx;
        for (int k = 0; k < 3; k++) begin
          op_b[k] = pupt_pkg::HALF_SQRT2_Q30;
        end
      end
      pupt_pkg::MUL_ATT_B: begin
        op_a[0] = iqz - iqw;
        op_b[0] = pupt_pkg::HALF_SQRT2_Q30;
      end
      pupt_pkg::MUL_SQ_A: begin
        op_a[0] = aw; op_b[0] = bw;
        op_a[1] = ax; op_b[1] = bx;
        op_a[2] = ay; op_b[2] = by;
      end
      pupt_pkg::MUL_SQ_B: begin
        op_a[0] = az; op_b[0] = bz;
        op_a[1] = ax; op_b[1] = by;
        op_a[2] = aw; op_b[2] = bz;
      end
      pupt_pkg::MUL_SQ_C: begin
        op_a[0] = ax; op_b[0] = bz;
        op_a[1] = aw; op_b[1] = by;
        op_a[2] = ay; op_b[2] = bz;
      end
      pupt_pkg::MUL_SQ_D: begin
        op_a[0] = aw; op_b[0] = bx;
      end
      pupt_pkg::MUL_ROW: begin
        case (cw.mrow)
          pupt_pkg::ROW_X: for (int k = 0; k < 3; k++) op_a[k] = mat[0][k];
          pupt_pkg::ROW_Y: for (int k = 0; k < 3; k++) op_a[k] = mat[1][k];
          pupt_pkg::ROW_Z: for (int k = 0; k < 3; k++) op_a[k] = mat[2][k];
          default: begin
          end
        endcase
        op_b[0] = item_vx;
        op_b[1] = item_vy;
        op_b[2] = item_vz;
      end
    endcase
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mul_out[k] = op_a[k] * op_b[k];
    end
  end

  always_ff @(posedge clk) begin
    if (cw.mul != pupt_pkg::MUL_NONE) begin
      for (int k = 0; k < 3; k++) begin
        p[k] <= mul_out[k];
      end
    end
  end

  assign eww = {{(E_W-32){pww[31]}}, pww};
  assign exx = {{(E_W-32){pxx[31]}}, pxx};
  assign eyy = {{(E_W-32){pyy[31]}}, pyy};
  assign ezz = {{(E_W-32){pzz[31]}}, pzz};
  assign exy = {{(E_W-32){pxy[31]}}, pxy};
  assign ewz = {{(E_W-32){pwz[31]}}, pwz};
  assign exz = {{(E_W-32){pxz[31]}}, pxz};
  assign ewy = {{(E_W-32){pwy[31]}}, pwy};
  assign eyz = {{(E_W-32){pyz[31]}}, pyz};
  assign ewx = {{(E_W-32){pwx[31]}}, pwx};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ent[k] = '0;
    end
    case (cw.wrow)
      pupt_pkg::ROW_X: begin
        ent[0] = eww + exx - eyy - ezz;
        ent[1] = (exy - ewz) <<< 1;
        ent[2] = (exz + ewy) <<< 1;
      end
      pupt_pkg::ROW_Y: begin
        ent[0] = (exy + ewz) <<< 1;
        ent[1] = eww - exx + eyy - ezz;
        ent[2] = (eyz - ewx) <<< 1;
      end
      pupt_pkg::ROW_Z: begin
        ent[0] = (exz - ewy) <<< 1;
        ent[1] = (eyz + ewx) <<< 1;
        ent[2] = eww - exx - eyy + ezz;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (cw.wrow)
      pupt_pkg::ROW_X: row_origin = origin_east;
      pupt_pkg::ROW_Y: row_origin = origin_north;
      default: row_origin = origin_up;
    endcase
    row_sum = {{2{p[0][P_W-1]}}, p[0]} + {{2{p[1][P_W-1]}}, p[1]} +
              {{2{p[2][P_W-1]}}, p[2]} +
              ({{(S_W-32){row_origin[31]}}, row_origin} <<< QUAT_FRAC_BITS) + ROW_HALF;
    row_shift = row_sum >>> QUAT_FRAC_BITS;
    if (row_shift[S_W-1:31] == '0 || row_shift[S_W-1:31] == '1) begin
      row_out = row_shift[31:0];
    end else if (row_shift[S_W-1]) begin
      row_out = pupt_pkg::C32_MIN;
    end else begin
      row_out = pupt_pkg::C32_MAX;
    end
    for (int k = 0; k < 3; k++) begin
      res_next[k] = res[k];
    end
    if (cw.wb == pupt_pkg::WB_RES) begin
      case (cw.wrow)
        pupt_pkg::ROW_X: res_next[0] = row_out;
        pupt_pkg::ROW_Y: res_next[1] = row_out;
        pupt_pkg::ROW_Z: res_next[2] = row_out;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      res[k] <= res_next[k];
    end
    unique case (cw.wb)
      pupt_pkg::WB_PROD_A: begin
        pww <= p[0][31:0];
        pxx <= p[1][31:0];
        pyy <= p[2][31:0];
      end
      pupt_pkg::WB_PROD_B: begin
        pzz <= p[0][31:0];
        pxy <= p[1][31:0];
        pwz <= p[2][31:0];
      end
      pupt_pkg::WB_PROD_C: begin
        pxz <= p[0][31:0];
        pwy <= p[1][31:0];
        pyz <= p[2][31:0];
      end
      pupt_pkg::WB_PROD_D: begin
        pwx <= p[0][31:0];
      end
      pupt_pkg::WB_MAT: begin
        case (cw.wrow)
          pupt_pkg::ROW_X: for (int k = 0; k < 3; k++) mat[0][k] <= ent_round(ent[k]);
          pupt_pkg::ROW_Y: for (int k = 0; k < 3; k++) mat[1][k] <= ent_round(ent[k]);
          pupt_pkg::ROW_Z: for (int k = 0; k < 3; k++) mat[2][k] <= ent_round(ent[k]);
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_east <= '0;
      origin_north <= '0;
      origin_up <= '0;
      att_w <= ATT_ONE;
      att_x <= '0;
      att_y <= '0;
      att_z <= '0;
      pose_valid <= 1'b0;
    end else begin
      unique case (cw.wb)
        pupt_pkg::WB_ATT_WXY: begin
          origin_east <= item_vy;
          origin_north <= item_vx;
          origin_up <= neg_sat(item_vz);
          att_w <= att_round(p[0]);
          att_x <= att_round(p[1]);
          att_y <= att_round(p[2]);
          pose_valid <= 1'b1;
        end
        pupt_pkg::WB_ATT_Z: begin
          att_z <= att_round(p[0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (item_action == pupt_pkg::ACT_ODOM) begin
      result.kind = pupt_pkg::ACT_ODOM;
      result.out_x = origin_east;
      result.out_y = origin_north;
      result.out_z = origin_up;
      result.att_out_w = att_w;
      result.att_out_x = att_x;
      result.att_out_y = att_y;
      result.att_out_z = att_z;
      result.extra_a = item_ab;
      result.extra_b = item_aa;
      result.extra_c = neg_sat(item_ac);
      result.end_of_cloud = 1'b0;
    end else begin
      result.kind = pupt_pkg::ACT_POINT;
      result.out_x = res_next[0];
      result.out_y = res_next[1];
      result.out_z = res_next[2];
      result.att_out_w = '0;
      result.att_out_x = '0;
      result.att_out_y = '0;
      result.att_out_z = '0;
      result.extra_a = item_aa;
      result.extra_b = '0;
      result.extra_c = '0;
      result.end_of_cloud = item_last;
    end
  end

  a_point_needs_pose: assert property (@(posedge clk) disable iff (rst)
    (ctl.emit && item_action == pupt_pkg::ACT_POINT) |-> pose_valid)
    else $error("Point result issued without a valid pose.");

  a_pose_sticky: assert property (@(posedge clk) disable iff (rst)
    ($past(pose_valid) && !$past(rst)) |-> pose_valid)
    else $error("Pose valid flag dropped outside reset.");

endmodule

`default_nettype wire

FILE: rtl/core/pose_update_point_transform.sv
// Top level of the pose update and point transform block with the result register.
//
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_stall   action, vec_*, quat_*, aux_*, last_point
// result    out        out_valid / out_stall kind, out_*, att_out_*, extra_*, end_of_cloud
//
// A point request takes one matrix row per step through three shared multipliers.
// An odometry request forms the attitude and then the rotation matrix.
// A point request that arrives before any pose gives no result.
// The next request is taken in the last step of a program when the result register is free.
// A stalled result holds the sequencer in its last step with in_stall high.
// Synchronous reset clears the sequencer, the pose flag, the origin and sets unit attitude.
`default_nettype none

module pose_update_point_transform #(
  parameter int QUAT_FRAC_BITS = pupt_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  input  logic signed [15:0] quat_w,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [31:0] aux_a,
  input  logic signed [31:0] aux_b,
  input  logic signed [31:0] aux_c,
  input  logic               last_point,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic signed [15:0] att_out_w,
  output logic signed [15:0] att_out_x,
  output logic signed [15:0] att_out_y,
  output logic signed [15:0] att_out_z,
  output logic signed [31:0] extra_a,
  output logic signed [31:0] extra_b,
  output logic signed [31:0] extra_c,
  output logic               end_of_cloud
);

  pupt_pkg::cw_t       cw;
  pupt_pkg::seq_stat_t stat;
  pupt_pkg::seq_ctl_t  ctl;
  pupt_pkg::out_item_t result;
  pupt_pkg::out_item_t obuf;
  logic                pose_valid;

  assign stat.in_valid = in_valid;
  assign stat.action = action;
  assign stat.slot_free = !out_valid || !out_stall;
  assign stat.pose_valid = pose_valid;
  assign in_stall = !ctl.ready;

  pupt_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cw   (cw),
    .ctl  (ctl)
  );

  pupt_dp #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cw         (cw),
    .ctl        (ctl),
    .action     (action),
    .vec_x      (vec_x),
    .vec_y      (vec_y),
    .vec_z      (vec_z),
    .quat_w     (quat_w),
    .quat_x     (quat_x),
    .quat_y     (quat_y),
    .quat_z     (quat_z),
    .aux_a      (aux_a),
    .aux_b      (aux_b),
    .aux_c      (aux_c),
    .last_point (last_point),
    .pose_valid (pose_valid),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.slot_free) begin
      out_valid <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      obuf <= result;
    end
  end

  assign kind = obuf.kind;
  assign out_x = obuf.out_x;
  assign out_y = obuf.out_y;
  assign out_z = obuf.out_z;
  assign att_out_w = obuf.att_out_w;
  assign att_out_x = obuf.att_out_x;
  assign att_out_y = obuf.att_out_y;
  assign att_out_z = obuf.att_out_z;
  assign extra_a = obuf.extra_a;
  assign extra_b = obuf.extra_b;
  assign extra_c = obuf.extra_c;
  assign end_of_cloud = obuf.end_of_cloud;

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |=> out_valid)
    else $error("Issued result not presented on the output.");

endmodule

`default_nettype wire

FILE: verif/pose_update_point_transform_test.sv
// Self-checking testbench for the pose update and point transform block.
`default_nettype none

module pose_update_point_transform_test;

  typedef struct {
    logic               action;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] aux_a;
    logic signed [31:0] aux_b;
    logic signed [31:0] aux_c;
    logic               last_point;
  } request_t;

  typedef enum {STALL_NONE, STALL_HALF, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

  class enu_pose_tracker;
    logic signed [31:0]  origin_e;
    logic signed [31:0]  origin_n;
    logic signed [31:0]  origin_u;
    logic signed [15:0]  att_w;
    logic signed [15:0]  att_x;
    logic signed [15:0]  att_y;
    logic signed [15:0]  att_z;
    bit                  pose_valid;
    pupt_pkg::out_item_t pending_results[$];
    int                  errors;

    function new();
      origin_e = '0;
      origin_n = '0;
      origin_u = '0;
      att_w = 16'sd1 <<< pupt_pkg::QUAT_FRAC_BITS_DEF;
      att_x = '0;
      att_y = '0;
      att_z = '0;
      pose_valid = 1'b0;
      errors = 0;
    endfunction

    function longint round_half_up(longint v, int k);
      return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function logic [31:0] sat32(longint v);
      if (v > 2147483647) return pupt_pkg::C32_MAX;
      if (v < -64'sd2147483648) return pupt_pkg::C32_MIN;
      return v[31:0];
    endfunction

    function logic [15:0] sat16(longint v);
      if (v > 32767) return pupt_pkg::Q16_MAX;
      if (v < -32768) return pupt_pkg::Q16_MIN;
      return v[15:0];
    endfunction

    function logic [15:0] half_sqrt2_scale(longint sum);
      return sat16(round_half_up(sum * pupt_pkg::HALF_SQRT2_Q30, pupt_pkg::ATT_SHIFT));
    endfunction

    function void note_request(request_t r);
      longint              vx, vy, vz, qw, qx, qy, qz;
      longint              w, x, y, z;
      longint              m[9];
      longint              acc[3];
      pupt_pkg::out_item_t want;
      int                  k;
      vx = r.vec_x;
      vy = r.vec_y;
      vz = r.vec_z;
      want = '0;
      if (r.action == pupt_pkg::ACT_ODOM) begin
        qw = r.quat_w;
        qx = r.quat_x;
        qy = r.quat_y;
        qz = r.quat_z;
        origin_e = r.vec_y;
        origin_n = r.vec_x;
        origin_u = sat32(-vz);
        att_w = half_sqrt2_scale(-(qw + qz));
        att_x = half_sqrt2_scale(-(qx + qy));
        att_y = half_sqrt2_scale(qy - qx);
        att_z = half_sqrt2_scale(qz - qw);
        pose_valid = 1'b1;
        want.kind = pupt_pkg::ACT_ODOM;
        want.out_x = origin_e;
        want.out_y = origin_n;
        want.out_z = origin_u;
        want.att_out_w = att_w;
        want.att_out_x = att_x;
        want.att_out_y = att_y;
        want.att_out_z = att_z;
        want.extra_a = r.aux_b;
        want.extra_b = r.aux_a;
        want.extra_c = sat32(-longint'(r.aux_c));
        pending_results = {pending_results, want};
      end else if (pose_valid) begin
        w = att_w;
        x = att_x;
        y = att_y;
        z = att_z;
        m[0] = w * w + x * x - y * y - z * z;
        m[1] = 2 * (x * y - w * z);
        m[2] = 2 * (x * z + w * y);
        m[3] = 2 * (x * y + w * z);
        m[4] = w * w - x * x + y * y - z * z;
        m[5] = 2 * (y * z - w * x);
        m[6] = 2 * (x * z - w * y);
        m[7] = 2 * (y * z + w * x);
        m[8] = w * w - x * x - y * y + z * z;
        for (k = 0; k < 9; k++) m[k] = round_half_up(m[k], pupt_pkg::QUAT_FRAC_BITS_DEF);
        for (k = 0; k < 3; k++) begin
          acc[k] = round_half_up(m[3*k] * vx + m[3*k+1] * vy + m[3*k+2] * vz,
                                 pupt_pkg::QUAT_FRAC_BITS_DEF);
        end
        want.kind = pupt_pkg::ACT_POINT;
        want.out_x = sat32(acc[0] + origin_e);
        want.out_y = sat32(acc[1] + origin_n);
        want.out_z = sat32(acc[2] + origin_u);
        want.extra_a = r.aux_a;
        want.end_of_cloud = r.last_point;
        pending_results = {pending_results, want};
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        errors++;
        $error("%s: expected %h, actual %h", name, want, seen);
      end
    endfunction

    function void check_result(pupt_pkg::out_item_t seen);
      pupt_pkg::out_item_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $error("result arrived with no request pending");
        return;
      end
      want = pending_results.pop_front();
      compare_field("kind", want.kind, seen.kind);
      compare_field("out_x", want.out_x, seen.out_x);
      compare_field("out_y", want.out_y, seen.out_y);
      compare_field("out_z", want.out_z, seen.out_z);
      compare_field("att_out_w", want.att_out_w, seen.att_out_w);
      compare_field("att_out_x", want.att_out_x, seen.att_out_x);
      compare_field("att_out_y", want.att_out_y, seen.att_out_y);
      compare_field("att_out_z", want.att_out_z, seen.att_out_z);
      compare_field("extra_a", want.extra_a, seen.extra_a);
      compare_field("extra_b", want.extra_b, seen.extra_b);
      compare_field("extra_c", want.extra_c, seen.extra_c);
      compare_field("end_of_cloud", want.end_of_cloud, seen.end_of_cloud);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               action = 1'b0;
  logic signed [31:0] vec_x = '0;
  logic signed [31:0] vec_y = '0;
  logic signed [31:0] vec_z = '0;
  logic signed [15:0] quat_w = '0;
  logic signed [15:0] quat_x = '0;
  logic signed [15:0] quat_y = '0;
  logic signed [15:0] quat_z = '0;
  logic signed [31:0] aux_a = '0;
  logic signed [31:0] aux_b = '0;
  logic signed [31:0] aux_c = '0;
  logic               last_point = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               kind;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [15:0] att_out_w;
  logic signed [15:0] att_out_x;
  logic signed [15:0] att_out_y;
  logic signed [15:0] att_out_z;
  logic signed [31:0] extra_a;
  logic signed [31:0] extra_b;
  logic signed [31:0] extra_c;
  logic               end_of_cloud;

  enu_pose_tracker tracker = new();
  request_t        request_q[$];
  bit              hold_off_req = 1'b0;

  pose_update_point_transform dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    pupt_pkg::out_item_t seen;
    request_t            req;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        seen = {kind, out_x, out_y, out_z, att_out_w, att_out_x, att_out_y, att_out_z,
                extra_a, extra_b, extra_c, end_of_cloud};
        tracker.check_result(seen);
      end
      if (in_valid && !in_stall) begin
        req.action = action;
        req.vec_x = vec_x;
        req.vec_y = vec_y;
        req.vec_z = vec_z;
        req.quat_w = quat_w;
        req.quat_x = quat_x;
        req.quat_y = quat_y;
        req.quat_z = quat_z;
        req.aux_a = aux_a;
        req.aux_b = aux_b;
        req.aux_c = aux_c;
        req.last_point = last_point;
        tracker.note_request(req);
      end
    end
  end

  initial begin
    stall_mode_t mode;
    int          mode_left;
    mode = STALL_NONE;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_HALF:  out_stall <= ($urandom_range(0, 1) == 1);
          STALL_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3, 4: return $urandom;
      default: return $signed($urandom_range(0, 32'h1fffff)) - 32'sd1048576;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_quat();
    logic [31:0] raw;
    raw = $urandom;
    if ($urandom_range(0, 4) == 0) return raw[15:0];
    return 16'($urandom_range(0, 32768)) - 16'd16384;
  endfunction

  function automatic request_t odom_req(logic signed [31:0] n, logic signed [31:0] e,
                                        logic signed [31:0] d, logic signed [15:0] qw,
                                        logic signed [15:0] qx, logic signed [15:0] qy,
                                        logic signed [15:0] qz, logic signed [31:0] vn,
                                        logic signed [31:0] ve, logic signed [31:0] vd,
                                        logic lp);
    request_t r;
    r.action = pupt_pkg::ACT_ODOM;
    r.vec_x = n;
    r.vec_y = e;
    r.vec_z = d;
    r.quat_w = qw;
    r.quat_x = qx;
    r.quat_y = qy;
    r.quat_z = qz;
    r.aux_a = vn;
    r.aux_b = ve;
    r.aux_c = vd;
    r.last_point = lp;
    return r;
  endfunction

  function automatic request_t point_req(logic signed [31:0] px, logic signed [31:0] py,
                                         logic signed [31:0] pz, logic signed [31:0] intensity,
                                         logic lp);
    request_t r;
    r.action = pupt_pkg::ACT_POINT;
    r.vec_x = px;
    r.vec_y = py;
    r.vec_z = pz;
    {r.quat_w, r.quat_x} = $urandom;
    {r.quat_y, r.quat_z} = $urandom;
    r.aux_a = intensity;
    r.aux_b = $urandom;
    r.aux_c = $urandom;
    r.last_point = lp;
    return r;
  endfunction

  task automatic queue_request(input request_t r);
    request_q = {request_q, r};
  endtask

  task automatic drive_request(input request_t r);
    in_valid <= 1'b1;
    action <= r.action;
    vec_x <= r.vec_x;
    vec_y <= r.vec_y;
    vec_z <= r.vec_z;
    quat_w <= r.quat_w;
    quat_x <= r.quat_x;
    quat_y <= r.quat_y;
    quat_z <= r.quat_z;
    aux_a <= r.aux_a;
    aux_b <= r.aux_b;
    aux_c <= r.aux_c;
    last_point <= r.last_point;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic play_requests();
    int burst;
    int gap;
    burst = 0;
    while (request_q.size() > 0) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      drive_request(request_q.pop_front());
      burst--;
    end
  endtask

  task automatic wait_drained();
    int waited;
    in_valid <= 1'b0;
    waited = 0;
    while (tracker.pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
  endtask

  initial begin
    int sent;
    int cloud;
    int k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Points that arrive before any pose must be dropped.
    queue_request(point_req(32'sh7fffffff, 32'sh80000000, 32'sh12345678, 32'sh7fffffff,
                            1'b1));
    queue_request(point_req(32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0));
    queue_request(odom_req(32'sd0, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0,
                           32'sd0, 32'sd0, 32'sd0, 1'b0));
    queue_request(point_req(32'sh00010000, 32'sh00020000, 32'shfffd0000, 32'sd77, 1'b0));
    queue_request(point_req(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                            1'b1));
    // Down position and east and down velocity at the most negative value, attitude terms out of range,
    // and a last-point mark on an odometry request.
    queue_request(odom_req(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 16'sh7fff,
                           16'sh7fff, 16'sh8000, 16'sh8000, 32'sh7fffffff,
                           32'sh80000000, 32'sh80000000, 1'b1));
    queue_request(point_req(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff,
                            1'b0));
    queue_request(point_req(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sd0, 1'b1));
    queue_request(odom_req(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 16'sh8000,
                           16'sh8000, 16'sh8000, 16'sh8000, 32'sh80000000,
                           32'sh7fffffff, 32'sh7fffffff, 1'b0));
    queue_request(point_req(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh55555555,
                            1'b0));
    queue_request(point_req(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'shaaaaaaaa,
                            1'b1));
    queue_request(point_req(32'sh00008000, 32'shffff8000, 32'sh00000001, 32'sd0, 1'b0));
    queue_request(odom_req(32'sh00100000, 32'shfff00000, 32'sh00050000, 16'sd11585,
                           16'sd0, 16'sd0, 16'sd11585, 32'sh00018000, 32'shfffe0000,
                           32'sh00004000, 1'b0));
    queue_request(point_req(32'sh00010000, 32'sd0, 32'sd0, 32'sd1, 1'b0));
    queue_request(point_req(32'sd0, 32'sh00010000, 32'sd0, 32'sd2, 1'b0));
    queue_request(point_req(32'sd0, 32'sd0, 32'sh00010000, 32'sd3, 1'b1));
    queue_request(odom_req(32'sd0, 32'sd0, 32'sh7fffffff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                           16'sh7fff, 32'sd0, 32'sd0, 32'sh80000001, 1'b0));
    queue_request(point_req(32'sh00001234, 32'shffffedcb, 32'sh00100000, 32'sh7fffffff,
                            1'b1));
    play_requests();
    wait_drained();

    // The result side holds off for a long stretch while points keep coming.
    queue_request(odom_req(pick_coord(), pick_coord(), pick_coord(), pick_quat(),
                           pick_quat(), pick_quat(), pick_quat(), $urandom, $urandom,
                           $urandom, 1'b0));
    for (k = 0; k < 40; k++) begin
      queue_request(point_req(pick_coord(), pick_coord(), pick_coord(), $urandom, k == 39));
    end
    hold_off_req = 1'b1;
    play_requests();

    sent = 0;
    while (sent < 840) begin
      queue_request(odom_req(pick_coord(), pick_coord(), pick_coord(), pick_quat(),
                             pick_quat(), pick_quat(), pick_quat(), $urandom, $urandom,
                             $urandom, $urandom_range(0, 7) == 0));
      cloud = $urandom_range(1, 24);
      for (k = 0; k < cloud; k++) begin
        queue_request(point_req(pick_coord(), pick_coord(), pick_coord(),
                                ($urandom_range(0, 5) == 0) ? 32'sd0 : $urandom,
                                (k == cloud - 1) || ($urandom_range(0, 15) == 0)));
      end
      sent += cloud + 1;
      play_requests();
    end
    wait_drained();

    if (tracker.pending_results.size() != 0) begin
      tracker.errors++;
      $error("%0d expected results never arrived", tracker.pending_results.size());
    end
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
